// ----- hdl/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK converter package
// Shared widths, constants and the types passed between the front end, the
// work queue and the divider back end.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int CHANNEL_BITS   = 8;
    localparam int NUM_BITS       = 2 * CHANNEL_BITS;
    localparam int IN_FIELD_BITS  = 3 * CHANNEL_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 4 * CHANNEL_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int LANES          = 3;

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [NUM_BITS-1:0]     t_num;

    localparam t_chan CHAN_FULL = '1;
    localparam t_chan CHAN_ZERO = '0;

    // One classified pixel: numerators and divisor of the three divisions.
    typedef struct packed {
        logic               full_black;
        t_chan              black;
        t_chan              span;
        t_num [LANES-1:0]   num;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // One divider stage: partial remainders and quotient bits so far.
    typedef struct packed {
        logic               full_black;
        t_chan              black;
        t_chan              span;
        t_num [LANES-1:0]   rem;
        t_chan [LANES-1:0]  quo;
    } t_stage;

endpackage

// ----- hdl/rtc_front.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK front end
// Accepts pixels, forms complements, black and the division operands, and
// pushes them into the work queue.
// ----------------------------------------------------------------------------
module rtc_front
    import rtc_pkg::*;
(
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0] i_s_axis_tdata,  // red, green, blue
    input  t_queue_status           i_status,
    output logic                    o_push,
    output t_work                   o_item
);

    // (comp - black) * FULL, with FULL = 2^N - 1 written as a shift and subtract.
    function automatic t_num scaled_diff(input t_chan comp, input t_chan blk);
        t_chan diff;
        diff = comp - blk;
        return {diff, CHAN_ZERO} - NUM_BITS'(diff);
    endfunction

    t_chan w_comp_c;
    t_chan w_comp_m;
    t_chan w_comp_y;
    t_chan w_min_cm;
    t_chan w_black;

    assign w_comp_c = CHAN_FULL - i_s_axis_tdata[0 +: CHANNEL_BITS];
    assign w_comp_m = CHAN_FULL - i_s_axis_tdata[CHANNEL_BITS +: CHANNEL_BITS];
    assign w_comp_y = CHAN_FULL - i_s_axis_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];

    assign w_min_cm = (w_comp_m < w_comp_c) ? w_comp_m : w_comp_c;
    assign w_black  = (w_comp_y < w_min_cm) ? w_comp_y : w_min_cm;

    always_comb begin
        o_item.full_black = (w_black == CHAN_FULL);
        o_item.black      = w_black;
        o_item.span       = CHAN_FULL - w_black;
        o_item.num[0]     = scaled_diff(w_comp_c, w_black);
        o_item.num[1]     = scaled_diff(w_comp_m, w_black);
        o_item.num[2]     = scaled_diff(w_comp_y, w_black);
    end

    assign o_s_axis_tready = !i_status.full;
    assign o_push          = i_s_axis_tvalid && !i_status.full;

endmodule

// ----- hdl/rtc_queue.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK work queue
// Small FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module rtc_queue
    import rtc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_work         i_item,
    input  logic          i_pop,
    output t_queue_status o_status,
    output t_work         o_head
);

    t_work                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_status.full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/rtc_back.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK divider back end
// Restoring division pipeline, one quotient bit per stage for three lanes,
// with the last stage serving as the output register.
// ----------------------------------------------------------------------------
module rtc_back
    import rtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_work                    i_head,
    input  t_queue_status            i_status,
    output logic                     o_pop,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata   // cyan, magenta, yellow, black
);

    logic   r_vld   [CHANNEL_BITS];
    t_stage r_stage [CHANNEL_BITS];
    t_stage w_entry;
    t_stage w_last;
    logic   w_adv;

    // The whole pipeline moves together whenever the output slot frees up.
    assign w_adv = !r_vld[CHANNEL_BITS-1] || i_m_axis_tready;
    assign o_pop = w_adv && !i_status.empty;

    always_comb begin
        w_entry.full_black = i_head.full_black;
        w_entry.black      = i_head.black;
        w_entry.span       = i_head.span;
        w_entry.rem        = i_head.num;
        w_entry.quo        = '0;
    end

    for (genvar k = 0; k < CHANNEL_BITS; k++) begin : g_stage
        localparam int SHIFT = CHANNEL_BITS - 1 - k;
        t_stage w_src;
        t_stage w_nxt;
        logic   w_vld_src;

        if (k == 0) begin : g_first
            assign w_src     = w_entry;
            assign w_vld_src = !i_status.empty;
        end else begin : g_next
            assign w_src     = r_stage[k-1];
            assign w_vld_src = r_vld[k-1];
        end

        always_comb begin
            t_num shifted;
            shifted = t_num'(w_src.span) << SHIFT;
            w_nxt   = w_src;
            for (int l = 0; l < LANES; l++) begin
                if (w_src.rem[l] >= shifted) begin
                    w_nxt.rem[l]        = w_src.rem[l] - shifted;
                    w_nxt.quo[l][SHIFT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_stage[k] <= w_nxt;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= w_vld_src;
            end
        end
    end

    assign w_last          = r_stage[CHANNEL_BITS-1];
    assign o_m_axis_tvalid = r_vld[CHANNEL_BITS-1];
    assign o_m_axis_tdata  = OUT_DATA_BITS'({
        w_last.black,
        w_last.full_black ? CHAN_ZERO : w_last.quo[2],
        w_last.full_black ? CHAN_ZERO : w_last.quo[1],
        w_last.full_black ? CHAN_ZERO : w_last.quo[0]
    });

endmodule

// ----- hdl/rgb_to_cmyk_convert.sv -----
// ----------------------------------------------------------------------------
// RGB to CMYK converter, naive black extraction
// Path from transaction accept to the result on the master side: the queue is
// written at the accepting edge, then the pixel moves through the divider stage
// registers in order. Throughput: one pixel per cycle while the master side
// accepts results, set by the fully pipelined divider.
// Reset: synchronous, active low; clears queue pointers and stage valids.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_convert
    import rtc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,   // red, green, blue
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata    // cyan, magenta, yellow, black
);

    // The front end computes the complements, black (the smallest
    // complement) and, for each ink, the numerator (complement - black) * FULL
    // and the divisor FULL - black. A pixel whose inputs are all zero is
    // flagged as full black so that the back end forces the inks to zero.
    t_queue_status w_status;
    t_work         w_item;
    t_work         w_head;
    logic          w_push;
    logic          w_pop;

    rtc_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_status        (w_status),
        .o_push          (w_push),
        .o_item          (w_item)
    );

    // A short queue lets the front keep taking transactions while the
    // divider pipeline is stalled by the master side.
    rtc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_status (w_status),
        .o_head   (w_head)
    );

    // The back end is a restoring divider with one stage per quotient bit
    // for all three inks in parallel; its last stage drives the outputs.
    rtc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_status        (w_status),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Field views of the result, used by the checks below.
    t_chan w_out_cyan;
    t_chan w_out_magenta;
    t_chan w_out_yellow;
    t_chan w_out_black;

    assign w_out_cyan    = o_m_axis_tdata[0 +: CHANNEL_BITS];
    assign w_out_magenta = o_m_axis_tdata[CHANNEL_BITS +: CHANNEL_BITS];
    assign w_out_yellow  = o_m_axis_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign w_out_black   = o_m_axis_tdata[3*CHANNEL_BITS +: CHANNEL_BITS];

    // A full-black result carries no colored ink.
    a_full_black_no_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_out_black == CHAN_FULL)) |->
        ((w_out_cyan == CHAN_ZERO) && (w_out_magenta == CHAN_ZERO) &&
         (w_out_yellow == CHAN_ZERO)))
        else $error("full black result carries colored ink");

    // The ink that set black always divides down to zero.
    a_one_ink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        ((w_out_cyan == CHAN_ZERO) || (w_out_magenta == CHAN_ZERO) ||
         (w_out_yellow == CHAN_ZERO)))
        else $error("no ink channel is zero after black removal");

    // The queue never takes a transaction while full.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.full |-> !w_push)
        else $error("push into a full work queue");

endmodule
